// ===== hw/rtl/hermitian_rank1_update_core_defines.svh =====
// ----------------------------------------------------------------------------
// Hermitian rank-1 update core: assertion macros
// Wrappers for concurrent assertions that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HERMITIAN_RANK1_UPDATE_CORE_DEFINES_SVH
`define HERMITIAN_RANK1_UPDATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HR1U_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hermitian_rank1_update_core: assertion failed");
// Next-cycle implication, disabled during reset.
`define HR1U_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hermitian_rank1_update_core: assertion failed");
`else
`define HR1U_ASSERT_NOW(label, clk, rst, ante, cons)
`define HR1U_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/hr1u_pkg.sv =====
// ----------------------------------------------------------------------------
// Hermitian rank-1 update package
// Field widths, item and register codes shared by the update core.
// ----------------------------------------------------------------------------
package hr1u_pkg;

  localparam int MAX_ORDER_DEFAULT = 64;

  localparam int IDX_W   = 6;   // row and column index width
  localparam int ORDER_W = 7;   // order register width
  localparam int X_W     = 16;  // vector element part, Q2.13
  localparam int A_W     = 32;  // matrix element part, 13 fraction bits
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int CFG_IDX_W = 2;

  // Input tdata: row, col, x_real, x_imag, a_real, a_imag, padded to bytes.
  localparam int IN_BITS   = 2 * IDX_W + 2 * X_W + 2 * A_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  // Output tdata: out_row, out_col, new_real, new_imag, padded to bytes.
  localparam int OUT_BITS   = 2 * IDX_W + 2 * A_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIANGLE = 2'd0,
    REG_ORDER    = 2'd1,
    REG_ALPHA    = 2'd2
  } cfg_reg_t;

  // Per-element control that travels with the data down the pipeline.
  typedef struct packed {
    logic upd;   // element receives the rank-1 term
    logic diag;  // element lies on the diagonal
  } ctl_t;

endpackage

// ===== hw/rtl/hermitian_rank1_update_core.sv =====
// ----------------------------------------------------------------------------
// Hermitian rank-1 update core
// Streams matrix elements of one triangle and adds alpha*x*conj(x)^T to them.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  ---------------------------------------------------
//  s_*       in         loads of x entries and matrix elements to update
//  m_*       out        one updated matrix element per update transfer
//  cfg_*     in         register writes: triangle, order, alpha
//
// Each element passes through the vector store read, then products, cross
// sums, alpha scaling, rounding, and the final add with saturation into the
// output register. The vector store has two read ports and one write port,
// so one transfer is taken every cycle unless the full pipeline is stalled.
// Every stage holds only while the stage after it is full and stalled, so
// bubbles close up and the input keeps flowing while a result waits. Reset
// clears valid bits and config registers; the vector store is not cleared.
//
`include "hermitian_rank1_update_core_defines.svh"

module hermitian_rank1_update_core #(
  parameter int MAX_ORDER = hr1u_pkg::MAX_ORDER_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream. tdata, low bit first: row[5:0], col[11:6], x_real[27:12],
  // x_imag[43:28], a_real[75:44], a_imag[107:76], zero padding.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hr1u_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,   // mode
  // Output stream. tdata, low bit first: out_row[5:0], out_col[11:6],
  // new_real[43:12], new_imag[75:44], zero padding.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [hr1u_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tuser,   // saturated
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [hr1u_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hr1u_pkg::CFG_W-1:0]        cfg_data
);
  import hr1u_pkg::*;

  // Only 64 entries are reachable with a six-bit index; beyond MAX_ORDER the
  // store does not exist and loads there are dropped.
  localparam logic [ORDER_W-1:0] LIMIT =
    (MAX_ORDER < (1 << IDX_W)) ? ORDER_W'(MAX_ORDER) : ORDER_W'(1 << IDX_W);
  localparam int DEPTH  = int'(LIMIT);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int P_W = 2 * X_W;        // single product
  localparam int S_W = P_W + 1;        // cross sum
  localparam int Q_W = S_W + X_W;      // scaled by alpha, 39 fraction bits
  localparam int R_W = Q_W - 26;       // rounded to 13 fraction bits
  localparam int T_W = A_W + 2;        // final sum with headroom

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                    tri_sel;
  logic [ORDER_W-1:0]      order_n;
  logic signed [X_W-1:0]   alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_sel <= 1'b0;
      order_n <= '0;
      alpha   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIANGLE: tri_sel <= cfg_data[0];
        REG_ORDER:    order_n <= cfg_data[ORDER_W-1:0];
        REG_ALPHA:    alpha   <= cfg_data[X_W-1:0];
        default: ;    // writes to unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking and element classification
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [X_W-1:0]   in_xr, in_xi;
  logic signed [A_W-1:0]   in_ar, in_ai;
  logic [ORDER_W-1:0]      n_eff, row7, col7;
  logic                    in_tri, accept, is_load;
  ctl_t                    in_ctl;

  assign in_row = s_tdata[IDX_W-1:0];
  assign in_col = s_tdata[2*IDX_W-1:IDX_W];
  assign in_xr  = s_tdata[2*IDX_W+X_W-1:2*IDX_W];
  assign in_xi  = s_tdata[2*IDX_W+2*X_W-1:2*IDX_W+X_W];
  assign in_ar  = s_tdata[2*IDX_W+2*X_W+A_W-1:2*IDX_W+2*X_W];
  assign in_ai  = s_tdata[IN_BITS-1:2*IDX_W+2*X_W+A_W];

  assign accept  = s_tvalid && s_tready;
  assign is_load = (mode_t'(s_tuser) == MODE_LOAD);

  assign n_eff  = (order_n < LIMIT) ? order_n : LIMIT;
  assign row7   = {1'b0, in_row};
  assign col7   = {1'b0, in_col};
  assign in_tri = tri_sel ? (in_row >= in_col) : (in_row <= in_col);

  assign in_ctl.upd  = in_tri && (row7 < n_eff) && (col7 < n_eff) && (alpha != '0);
  assign in_ctl.diag = (in_row == in_col);

  // --------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || m_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= accept && !is_load;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Vector store: one write port, two registered read ports. A load written
  // at one edge is seen by an update read at any later edge.
  // --------------------------------------------------------------------------
  logic [2*X_W-1:0]        vec_mem [DEPTH];
  logic [2*X_W-1:0]        rd_row, rd_col;

  always_ff @(posedge clk) begin
    if (accept && is_load && (row7 < LIMIT)) begin
      vec_mem[in_row[ADDR_W-1:0]] <= {in_xi, in_xr};
    end
    if (en1) begin
      rd_row <= vec_mem[in_row[ADDR_W-1:0]];
      rd_col <= vec_mem[in_col[ADDR_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Element payload carried alongside the arithmetic
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]        row1, row2, row3, row4, row5, row6;
  logic [IDX_W-1:0]        col1, col2, col3, col4, col5, col6;
  logic signed [A_W-1:0]   ar1, ar2, ar3, ar4, ar5;
  logic signed [A_W-1:0]   ai1, ai2, ai3, ai4, ai5;
  ctl_t                    ctl1, ctl2, ctl3, ctl4, ctl5, ctl6;

  always_ff @(posedge clk) begin
    if (en1) begin
      row1 <= in_row; col1 <= in_col; ar1 <= in_ar; ai1 <= in_ai; ctl1 <= in_ctl;
    end
    if (en2) begin
      row2 <= row1; col2 <= col1; ar2 <= ar1; ai2 <= ai1; ctl2 <= ctl1;
    end
    if (en3) begin
      row3 <= row2; col3 <= col2; ar3 <= ar2; ai3 <= ai2; ctl3 <= ctl2;
    end
    if (en4) begin
      row4 <= row3; col4 <= col3; ar4 <= ar3; ai4 <= ai3; ctl4 <= ctl3;
    end
    if (en5) begin
      row5 <= row4; col5 <= col4; ar5 <= ar4; ai5 <= ai4; ctl5 <= ctl4;
    end
    if (en6) begin
      row6 <= row5; col6 <= col5; ctl6 <= ctl5;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the four partial products of x_row * conj(x_col).
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0]   xrr, xri, xcr, xci;
  logic signed [P_W-1:0]   p_rr, p_ii, p_ir, p_ri;

  assign xrr = rd_row[X_W-1:0];
  assign xri = rd_row[2*X_W-1:X_W];
  assign xcr = rd_col[X_W-1:0];
  assign xci = rd_col[2*X_W-1:X_W];

  always_ff @(posedge clk) begin
    if (en2) begin
      p_rr <= xrr * xcr;
      p_ii <= xri * xci;
      p_ir <= xri * xcr;
      p_ri <= xrr * xci;
    end
  end

  // Stage 3: real and imaginary parts of the product, 26 fraction bits.
  logic signed [S_W-1:0]   pre, pim;

  always_ff @(posedge clk) begin
    if (en3) begin
      pre <= S_W'(p_rr) + S_W'(p_ii);
      pim <= S_W'(p_ir) - S_W'(p_ri);
    end
  end

  // Stage 4: scaling by alpha, 39 fraction bits, exact.
  logic signed [Q_W-1:0]   qre, qim;

  always_ff @(posedge clk) begin
    if (en4) begin
      qre <= Q_W'(pre) * Q_W'(alpha);
      qim <= Q_W'(pim) * Q_W'(alpha);
    end
  end

  // Stage 5: round half toward plus infinity down to 13 fraction bits.
  localparam logic signed [Q_W-1:0] HALF = Q_W'(1) <<< 25;
  logic signed [Q_W-1:0]   qre_h, qim_h;
  logic signed [R_W-1:0]   rre, rim;

  assign qre_h = qre + HALF;
  assign qim_h = qim + HALF;

  always_ff @(posedge clk) begin
    if (en5) begin
      rre <= qre_h[Q_W-1:26];
      rim <= qim_h[Q_W-1:26];
    end
  end

  // Stage 6: add to the element and clip to the 32-bit range.
  localparam logic signed [A_W-1:0] A_MAX = {1'b0, {(A_W-1){1'b1}}};
  localparam logic signed [A_W-1:0] A_MIN = {1'b1, {(A_W-1){1'b0}}};

  logic signed [T_W-1:0]   tre, tim;
  logic                    ovf_re, ovf_im;
  logic signed [A_W-1:0]   cre, cim;
  logic signed [A_W-1:0]   nre_next, nim_next;
  logic                    sat_next;
  logic signed [A_W-1:0]   nre, nim;
  logic                    sat;

  assign tre = T_W'(ar5) + T_W'(rre);
  assign tim = T_W'(ai5) + T_W'(rim);

  // The sum fits when its top three bits agree.
  assign ovf_re = (tre[T_W-1:A_W-1] != '0) && (tre[T_W-1:A_W-1] != '1);
  assign ovf_im = (tim[T_W-1:A_W-1] != '0) && (tim[T_W-1:A_W-1] != '1);
  assign cre = ovf_re ? (tre[T_W-1] ? A_MIN : A_MAX) : tre[A_W-1:0];
  assign cim = ovf_im ? (tim[T_W-1] ? A_MIN : A_MAX) : tim[A_W-1:0];

  always_comb begin
    nre_next = ar5;
    nim_next = ai5;
    sat_next = 1'b0;
    if (ctl5.upd) begin
      nre_next = cre;
      if (ctl5.diag) begin
        nim_next = '0;
        sat_next = ovf_re;
      end else begin
        nim_next = cim;
        sat_next = ovf_re || ovf_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      nre <= nre_next;
      nim <= nim_next;
      sat <= sat_next;
    end
  end

  assign m_tvalid = v6;
  assign m_tuser  = sat;
  assign m_tdata  = OUT_DATA_W'({nim, nre, col6, row6});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A load never enters the result pipeline.
  `HR1U_ASSERT_NEXT(a_load_no_result, clk, rst,
    accept && is_load, !v1)
  // The input is held back only when every stage is full and the output stalls.
  `HR1U_ASSERT_NOW(a_ready_only_when_full, clk, rst,
    !s_tready, v1 && v2 && v3 && v4 && v5 && v6 && !m_tready)
  // An element left alone comes out unchanged and unclipped.
  `HR1U_ASSERT_NEXT(a_passthrough, clk, rst,
    v5 && en6 && !ctl5.upd,
    !m_tuser && (nre == $past(ar5)) && (nim == $past(ai5)))
  // An updated diagonal element has a zero imaginary part.
  `HR1U_ASSERT_NOW(a_diag_imag_zero, clk, rst,
    m_tvalid && ctl6.upd && ctl6.diag, nim == '0)

endmodule
